@@ hdl/ring_buffer_deque_defines.svh @@
// Shared assertion macros for the deque block.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rbd_pkg.sv @@
package rbd_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W        = 3;
  localparam int VAL_W       = 32;
  localparam int ERR_W       = 2;
  localparam int CNT_W       = 11;
  localparam int CAP_W       = 11;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int CAP_LIM     = 2047;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef struct packed {
    logic exec;
    logic land_rd;
  } cmd_t;

  typedef struct packed {
    logic rd_needed;
    logic skid_full;
  } sts_t;

endpackage

@@ hdl/ring_buffer_deque.sv @@
// Double-ended queue in a circular RAM of DEPTH entries, of which the capacity
// register selects how many are in use. Each input transaction carries one
// operation (push, pop or peek at either end) and yields exactly one result
// transaction with the data, an error code, the count after the operation and
// an empty flag. Results of pushes, failed operations and unused op codes land
// at acceptance; those of successful pops and peeks after the registered RAM read.
// A two-entry output stage lets the next transaction enter while a result
// waits. Writing the capacity register (clamped to 1..DEPTH) empties the queue
// and must happen while the block is idle. RAM contents are not cleared; only
// entries that were pushed are ever read.
module ring_buffer_deque #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // op [2:0], value [34:3], zero [39:35]
  input  logic [rbd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // data [31:0], error [33:32], count [44:34], is_empty [45], zero [47:46]
  output logic [rbd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rbd_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [rbd_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [rbd_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  rbd_pkg::cmd_t cmd;
  rbd_pkg::sts_t sts;

  assign cfg_pready = 1'b1;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rbd_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready),
    .cfg_addr   (cfg_paddr),
    .cfg_wdata  (cfg_pwdata),
    .cfg_rdata  (cfg_prdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ hdl/rbd_ram.sv @@
module rbd_ram #(
  parameter int WIDTH = rbd_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/rbd_ctrl.sv @@
`include "ring_buffer_deque_defines.svh"

module rbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output rbd_pkg::cmd_t cmd,
  input  rbd_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t st_r, st_nxt;

  assign in_tready   = (st_r == ST_IDLE) && !sts.skid_full;
  assign cmd.exec    = in_tvalid && in_tready;
  assign cmd.land_rd = (st_r == ST_READ);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (cmd.exec && sts.rd_needed) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  `RBD_ASSERT_NXT(a_read_one_cycle, clk, rst_n, st_r == ST_READ, st_r == ST_IDLE, "read wait overran")
  `RBD_ASSERT_NXT(a_read_follows, clk, rst_n, cmd.exec && sts.rd_needed, st_r == ST_READ, "read not started")

endmodule

@@ hdl/rbd_dp.sv @@
`include "ring_buffer_deque_defines.svh"

module rbd_dp #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rbd_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [rbd_pkg::CFG_DW-1:0]      cfg_wdata,
  output logic [rbd_pkg::CFG_DW-1:0]      cfg_rdata,
  input  logic [rbd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rbd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  rbd_pkg::cmd_t                   cmd,
  output rbd_pkg::sts_t                   sts
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CAP_W = rbd_pkg::CAP_W;
  localparam int CNT_W = rbd_pkg::CNT_W;
  localparam int IW    = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
  localparam logic [CAP_W-1:0] CAP_MAX =
    CAP_W'((DEPTH > rbd_pkg::CAP_LIM) ? rbd_pkg::CAP_LIM : DEPTH);

  localparam int OW = rbd_pkg::OUT_TDATA_W;

  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] c);
    logic [IW-1:0] n;
    n = IW'(p) + IW'(1);
    return (n >= IW'(c)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
    return ((p == '0) || (IW'(p) >= IW'(c))) ? PTR_W'(c - CAP_W'(1)) : p - PTR_W'(1);
  endfunction

  logic [CAP_W-1:0] cap_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [OW-1:0]        out_data_r, out_data_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic [OW-1:0]        skid_data_r, skid_data_nxt;

  rbd_pkg::op_t          op;
  logic [rbd_pkg::VAL_W-1:0] value;
  rbd_pkg::err_t         err;
  logic                  rd;
  logic                  we;
  logic [PTR_W-1:0]      waddr;
  logic [PTR_W-1:0]      raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  full;
  logic                  empty;
  logic                  land;
  logic [OW-1:0]         land_word;
  logic [CAP_W-1:0]      cap_wr;
  logic                  cfg_hit;

  assign op    = rbd_pkg::op_t'(in_tdata[rbd_pkg::OP_W-1:0]);
  assign value = in_tdata[rbd_pkg::OP_W +: rbd_pkg::VAL_W];
  assign full  = (cnt_r >= cap_r);
  assign empty = (cnt_r == '0);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    err      = rbd_pkg::ERR_NONE;
    rd       = 1'b0;
    we       = 1'b0;
    waddr    = head_r;
    raddr    = head_r;
    case (op)
      rbd_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          err = rbd_pkg::ERR_FULL;
        end else begin
          head_nxt = step_down(head_r, cap_r);
          we       = 1'b1;
          waddr    = head_nxt;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      rbd_pkg::OP_PUSH_BACK: begin
        if (full) begin
          err = rbd_pkg::ERR_FULL;
        end else begin
          tail_nxt = step_up(tail_r, cap_r);
          we       = 1'b1;
          waddr    = tail_nxt;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      rbd_pkg::OP_POP_FRONT: begin
        if (empty) begin
          err = rbd_pkg::ERR_EMPTY;
        end else begin
          rd       = 1'b1;
          raddr    = head_r;
          head_nxt = step_up(head_r, cap_r);
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      rbd_pkg::OP_POP_BACK: begin
        if (empty) begin
          err = rbd_pkg::ERR_EMPTY;
        end else begin
          rd       = 1'b1;
          raddr    = tail_r;
          tail_nxt = step_down(tail_r, cap_r);
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      rbd_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          err = rbd_pkg::ERR_EMPTY;
        end else begin
          rd    = 1'b1;
          raddr = head_r;
        end
      end
      rbd_pkg::OP_PEEK_BACK: begin
        if (empty) begin
          err = rbd_pkg::ERR_EMPTY;
        end else begin
          rd    = 1'b1;
          raddr = tail_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.rd_needed = rd;
  assign sts.skid_full = skid_valid_r;

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && we),
    .waddr (waddr),
    .wdata (DATA_WIDTH'(value)),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Non-read results land at acceptance; read results land in the cycle after acceptance.
  always_comb begin
    land = 1'b0;
    land_word = '0;
    if (cmd.land_rd) begin
      land      = 1'b1;
      land_word = {2'b00, (cnt_r == '0), cnt_r, rbd_pkg::ERR_NONE, 32'(ram_rdata)};
    end else if (cmd.exec && !rd) begin
      land      = 1'b1;
      land_word = {2'b00, (cnt_nxt == '0), cnt_nxt, err, 32'd0};
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (land) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = land_word;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = land_word;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_hit = (cfg_addr[2] == 1'b0);
  assign cfg_rdata = cfg_hit ? rbd_pkg::CFG_DW'(cap_r) : '0;

  always_comb begin
    cap_wr = cfg_wdata[CAP_W-1:0];
    if (cap_wr == '0) begin
      cap_wr = CAP_W'(1);
    end else if (cap_wr > CAP_MAX) begin
      cap_wr = CAP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_MAX;
      head_r       <= '0;
      tail_r       <= PTR_W'(CAP_MAX - CAP_W'(1));
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_we && cfg_hit) begin
        cap_r  <= cap_wr;
        head_r <= '0;
        tail_r <= PTR_W'(cap_wr - CAP_W'(1));
        cnt_r  <= '0;
      end else if (cmd.exec) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `RBD_ASSERT_IMP(a_cnt_in_cap, clk, rst_n, 1'b1, cnt_r <= cap_r, "count above capacity")
  `RBD_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid holds data ahead of output")
  `RBD_ASSERT_IMP(a_no_overrun, clk, rst_n, land, !skid_valid_r, "result landed on full output stage")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int IDLE_PCT       = 17;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 36;
  localparam int MAX_REPORTS    = 10;

  localparam logic [rbd_pkg::CFG_AW-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [rbd_pkg::OP_W-1:0]   OP_RSVD_6     = 3'd6;
  localparam logic [rbd_pkg::OP_W-1:0]   OP_RSVD_7     = 3'd7;

  typedef struct packed {
    logic                      is_empty;
    logic [rbd_pkg::CNT_W-1:0] count;
    rbd_pkg::err_t             error;
    logic [rbd_pkg::VAL_W-1:0] data;
  } deque_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // op [2:0], value [34:3], zero [39:35]
  logic [rbd_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // data [31:0], error [33:32], count [44:34], is_empty [45], zero [47:46]
  logic [rbd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [rbd_pkg::CFG_AW-1:0]      cfg_paddr;
  logic [rbd_pkg::CFG_DW-1:0]      cfg_pwdata;
  logic [rbd_pkg::CFG_DW-1:0]      cfg_prdata;
  logic                            cfg_pready;

  logic [rbd_pkg::VAL_W-1:0] shadow_store [rbd_pkg::DEPTH_DEF];
  int unsigned      shadow_head;
  int unsigned      shadow_tail;
  int unsigned      shadow_count;
  int unsigned      shadow_cap;

  deque_result_t pending_results[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  bit            idle_on = 1'b1;
  bit            rx_hold_req = 1'b0;

  ring_buffer_deque dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= shadow_cap) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned p);
    return (p == 0 || p >= shadow_cap) ? shadow_cap - 1 : p - 1;
  endfunction

  function automatic deque_result_t deque_apply(logic [rbd_pkg::OP_W-1:0] op,
                                                logic [rbd_pkg::VAL_W-1:0] value);
    deque_result_t r;
    r = '0;
    r.error = rbd_pkg::ERR_NONE;
    case (op)
      rbd_pkg::OP_PUSH_FRONT, rbd_pkg::OP_PUSH_BACK: begin
        if (shadow_count >= shadow_cap) begin
          r.error = rbd_pkg::ERR_FULL;
        end else if (op == rbd_pkg::OP_PUSH_FRONT) begin
          shadow_head = ring_prev(shadow_head);
          shadow_store[shadow_head] = value;
          shadow_count++;
        end else begin
          shadow_tail = ring_next(shadow_tail);
          shadow_store[shadow_tail] = value;
          shadow_count++;
        end
      end
      rbd_pkg::OP_POP_FRONT, rbd_pkg::OP_POP_BACK,
      rbd_pkg::OP_PEEK_FRONT, rbd_pkg::OP_PEEK_BACK: begin
        if (shadow_count == 0) begin
          r.error = rbd_pkg::ERR_EMPTY;
        end else if (op == rbd_pkg::OP_POP_FRONT || op == rbd_pkg::OP_PEEK_FRONT) begin
          r.data = shadow_store[shadow_head];
          if (op == rbd_pkg::OP_POP_FRONT) begin
            shadow_head = ring_next(shadow_head);
            shadow_count--;
          end
        end else begin
          r.data = shadow_store[shadow_tail];
          if (op == rbd_pkg::OP_POP_BACK) begin
            shadow_tail = ring_prev(shadow_tail);
            shadow_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.count = shadow_count[rbd_pkg::CNT_W-1:0];
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin : result_monitor
    deque_result_t want;
    deque_result_t predicted;
    logic          moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        predicted = deque_apply(in_tdata[rbd_pkg::OP_W-1:0],
                                in_tdata[rbd_pkg::OP_W+rbd_pkg::VAL_W-1:rbd_pkg::OP_W]);
        pending_results = {pending_results, predicted};
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result transaction tdata=%h", $realtime, out_tdata);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_tdata[31:0] !== want.data || out_tdata[33:32] !== want.error ||
              out_tdata[44:34] !== want.count || out_tdata[45] !== want.is_empty) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $write("%0t: mismatch exp data=%h err=%0d cnt=%0d empty=%0b",
                     $realtime, want.data, want.error, want.count, want.is_empty);
              $display(" act data=%h err=%0d cnt=%0d empty=%0b",
                       out_tdata[31:0], out_tdata[33:32], out_tdata[44:34], out_tdata[45]);
            end
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic send_op(input logic [rbd_pkg::OP_W-1:0] op,
                         input logic [rbd_pkg::VAL_W-1:0] value);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(rbd_pkg::IN_TDATA_W-rbd_pkg::VAL_W-rbd_pkg::OP_W){1'b0}}, value, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [rbd_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rbd_pkg::OP_W-1:0] pick_op(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      return $urandom_range(0, 1) ? rbd_pkg::OP_PUSH_FRONT : rbd_pkg::OP_PUSH_BACK;
    if (roll >= 95) return $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
    case ($urandom_range(0, 5))
      0, 1: return rbd_pkg::OP_POP_FRONT;
      2, 3: return rbd_pkg::OP_POP_BACK;
      4: return rbd_pkg::OP_PEEK_FRONT;
      default: return rbd_pkg::OP_PEEK_BACK;
    endcase
  endfunction

  task automatic send_random(input int push_pct);
    send_op(pick_op(push_pct), rand_value());
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [rbd_pkg::CAP_W-1:0] cap_value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_CAPACITY;
    cfg_pwdata <= {{(rbd_pkg::CFG_DW-rbd_pkg::CAP_W){1'b0}}, cap_value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    shadow_cap = (cap_value == 0) ? 1 :
                 (cap_value > rbd_pkg::DEPTH_DEF) ? rbd_pkg::DEPTH_DEF : cap_value;
    shadow_head = 0;
    shadow_tail = shadow_cap - 1;
    shadow_count = 0;
  endtask

  task automatic test_directed();
    send_op(rbd_pkg::OP_POP_FRONT, '1);
    send_op(rbd_pkg::OP_POP_BACK, '0);
    send_op(rbd_pkg::OP_PEEK_FRONT, '0);
    send_op(rbd_pkg::OP_PEEK_BACK, '0);
    send_op(OP_RSVD_6, 32'h1234_5678);
    send_op(OP_RSVD_7, '1);
    send_op(rbd_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(rbd_pkg::OP_PEEK_BACK, '0);
    send_op(rbd_pkg::OP_PEEK_FRONT, '0);
    send_op(rbd_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send_op(rbd_pkg::OP_PUSH_FRONT, 32'h8000_0001);
    send_op(OP_RSVD_6, '0);
    send_op(rbd_pkg::OP_POP_BACK, '0);
    send_op(rbd_pkg::OP_POP_BACK, '0);
    send_op(rbd_pkg::OP_POP_BACK, '0);
    send_op(rbd_pkg::OP_POP_FRONT, '0);
    wait_for_drain();
    write_capacity(11'd1);
    send_op(rbd_pkg::OP_PUSH_BACK, 32'hA5A5_5A5A);
    send_op(rbd_pkg::OP_PUSH_FRONT, 32'h5555_5555);
    send_op(rbd_pkg::OP_PUSH_BACK, 32'hAAAA_AAAA);
    send_op(rbd_pkg::OP_PEEK_FRONT, '0);
    send_op(rbd_pkg::OP_POP_FRONT, '0);
    send_op(rbd_pkg::OP_POP_BACK, '0);
    wait_for_drain();
    write_capacity(11'd0);
    send_op(rbd_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_op(rbd_pkg::OP_POP_BACK, '0);
  endtask

  task automatic test_random_phases();
    int caps [7];
    int push_pct [3];
    caps = '{2, 3, 5, 16, 1025, 40, 7};
    push_pct = '{70, 50, 35};
    caps[5] = $urandom_range(1, 64);
    for (int i = 0; i < 7; i++) begin
      wait_for_drain();
      write_capacity(rbd_pkg::CAP_W'(caps[i]));
      repeat (PHASE_ITEMS) send_random(push_pct[i % 3]);
    end
  endtask

  task automatic test_receiver_holdoff();
    rx_hold_req = 1'b1;
    repeat (24) send_random(60);
    wait (!rx_hold_req);
  endtask

  task automatic test_sender_pause();
    wait_for_drain();
    repeat (30) send_random(50);
  endtask

  task automatic test_full_capacity();
    wait_for_drain();
    write_capacity(11'h7FF);
    idle_on = 1'b0;
    repeat (rbd_pkg::DEPTH_DEF)
      send_op($urandom_range(0, 1) ? rbd_pkg::OP_PUSH_FRONT : rbd_pkg::OP_PUSH_BACK,
              rand_value());
    send_op(rbd_pkg::OP_PUSH_FRONT, '1);
    send_op(rbd_pkg::OP_PUSH_BACK, '1);
    send_op(rbd_pkg::OP_PEEK_FRONT, '0);
    send_op(rbd_pkg::OP_PEEK_BACK, '0);
    send_op(rbd_pkg::OP_POP_FRONT, '0);
    send_op(rbd_pkg::OP_POP_BACK, '0);
    idle_on = 1'b1;
    repeat (40) send_random(45);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    shadow_cap = rbd_pkg::DEPTH_DEF;
    shadow_head = 0;
    shadow_tail = shadow_cap - 1;
    shadow_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_receiver_holdoff();
    test_sender_pause();
    test_full_capacity();
    wait_for_drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
